>>> design/tap_hold_key_resolver_top_assert.svh
// Assertion macros for the tap-hold key resolver.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef TAP_HOLD_KEY_RESOLVER_TOP_ASSERT_SVH
`define TAP_HOLD_KEY_RESOLVER_TOP_ASSERT_SVH
`ifndef SYNTH
// condition holds in the same cycle as the antecedent
`define TAHR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tahr check failed");
// condition holds in the cycle after the antecedent
`define TAHR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tahr check failed");
`else
`define TAHR_ASSERT_SAME(lbl, ante, cons)
`define TAHR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> design/tahr_pkg.sv
`timescale 1ns / 1ps
package tahr_pkg;

  // Field widths
  localparam int SLOT_FW = 4;
  localparam int KEY_FW  = 6;
  localparam int CODE_FW = 8;
  localparam int TERM_FW = 16;
  localparam int TIME_FW = 32;
  localparam int MAP_FW  = 64;

  // Design defaults and limits
  localparam int NUM_SLOTS_DEF = 16;
  localparam int NUM_KEYS      = 64;
  localparam int MAX_RES       = 16;
  localparam int RES_CNT_W     = $clog2(MAX_RES + 1);

  // Request kinds
  localparam logic REQ_SWITCH = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // Result actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_TAP  = 2'd1;
  localparam logic [1:0] ACT_HOLD = 2'd2;

  typedef struct packed {
    logic                 req_type;
    logic [SLOT_FW-1:0]   slot;
    logic [KEY_FW-1:0]    key_index;
    logic                 switch_pressed;
    logic                 switch_was_pressed;
    logic                 binding_is_tap_hold;
    logic [CODE_FW-1:0]   tap_code;
    logic [CODE_FW-1:0]   hold_code;
    logic [TERM_FW-1:0]   tap_window;
    logic [TIME_FW-1:0]   now_time;
    logic                 other_key_pressed;
    logic [MAP_FW-1:0]    released_keys;
  } tahr_in_t;

  typedef struct packed {
    logic [SLOT_FW-1:0] out_slot;
    logic [KEY_FW-1:0]  out_key;
    logic [CODE_FW-1:0] out_keycode;
    logic [1:0]         action;
    logic               last;
  } tahr_out_t;

  // Contents of one binding slot
  typedef struct packed {
    logic [KEY_FW-1:0]  key;
    logic [TIME_FW-1:0] start;
    logic [CODE_FW-1:0] tap_code;
    logic [CODE_FW-1:0] hold_code;
    logic [TERM_FW-1:0] term;
  } tahr_slot_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } tahr_cell_ctl_t;

endpackage

>>> design/tahr_cell.sv
`timescale 1ns / 1ps
module tahr_cell
  import tahr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  tahr_cell_ctl_t ctl,
  input  tahr_slot_t     ld_data,
  input  logic           nb_armed,
  input  tahr_slot_t     nb_data,
  output logic           armed,
  output tahr_slot_t     data
);

  logic       armed_r, armed_nxt;
  tahr_slot_t data_r, data_nxt;

  // Load from a switch request, or take the neighbour's contents during a scan
  always_comb begin
    armed_nxt = armed_r;
    data_nxt  = data_r;
    if (ctl.load) begin
      armed_nxt = 1'b1;
      data_nxt  = ld_data;
    end else if (ctl.shift) begin
      armed_nxt = nb_armed;
      data_nxt  = nb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  // slot contents need no reset: read only while armed
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign armed = armed_r;
  assign data  = data_r;

endmodule

>>> design/tahr_judge.sv
`timescale 1ns / 1ps
module tahr_judge
  import tahr_pkg::*;
(
  input  logic               armed,
  input  tahr_slot_t         data,
  input  logic [TIME_FW-1:0] now_time,
  input  logic               other_key,
  input  logic [MAP_FW-1:0]  rel_map,
  output logic [1:0]         act
);

  logic [TIME_FW-1:0] elapsed;
  logic               is_mod;
  logic               rel;
  logic               in_term;

  // Wrapping elapsed time against the stored term
  assign elapsed = now_time - data.start;
  assign in_term = elapsed < {{(TIME_FW-TERM_FW){1'b0}}, data.term};
  assign is_mod  = data.hold_code inside {[8'hE0:8'hE7]};
  // keys at or above the key count never read as released
  assign rel     = rel_map[data.key] &&
                   ({1'b0, data.key} < (KEY_FW+1)'(NUM_KEYS));

  always_comb begin
    act = ACT_NONE;
    if (armed) begin
      if (other_key && is_mod) begin
        act = ACT_HOLD;
      end else if (rel && in_term) begin
        act = ACT_TAP;
      end else if (!rel && !in_term) begin
        act = ACT_HOLD;
      end
    end
  end

endmodule

>>> design/tap_hold_key_resolver_top.sv
`timescale 1ns / 1ps
// Switch request: busy stays low, one request per cycle, result strobed the cycle after.
// Tick request: busy through the scan, as the slot ring rotates once past the judge
// at cell 0 (one slot per cycle), and the flush; results stream out during the scan
// and the final one (last=1) is strobed in the first cycle with busy low again.
// Results cannot be held off. Synchronous active-low reset disarms every slot and idles
// the sequencer; slot contents are left as they are.
module tap_hold_key_resolver_top
  import tahr_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tahr_in_t  in_req,
  output logic      out_valid,
  output tahr_out_t out_res
);

  localparam int CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic [RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  tahr_out_t            pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tahr_out_t            out_r, out_nxt;
  logic [TIME_FW-1:0]   tick_now_r, tick_now_nxt;
  logic                 tick_other_r, tick_other_nxt;
  logic [MAP_FW-1:0]    tick_rel_r, tick_rel_nxt;

  logic           accept;
  logic           arm;
  tahr_slot_t     ld_data;
  logic [1:0]     head_act;
  logic           take;
  tahr_out_t      new_res;
  tahr_out_t      none_res;
  logic           wrap_armed;

  logic           cell_armed [NUM_SLOTS];
  tahr_slot_t     cell_data  [NUM_SLOTS];
  tahr_cell_ctl_t cell_ctl   [NUM_SLOTS];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign arm    = accept && (in_req.req_type == REQ_SWITCH) && in_req.switch_pressed &&
                  !in_req.switch_was_pressed && in_req.binding_is_tap_hold;

  assign ld_data.key       = in_req.key_index;
  assign ld_data.start     = in_req.now_time;
  assign ld_data.tap_code  = in_req.tap_code;
  assign ld_data.hold_code = in_req.hold_code;
  assign ld_data.term      = in_req.tap_window;

  // Ring of slot cells: each hands its contents to the one below during a scan
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic       nb_armed;
    tahr_slot_t nb_data;

    if (i < (1 << SLOT_FW)) begin : g_ld
      assign cell_ctl[i].load = arm && (in_req.slot == SLOT_FW'(i));
    end else begin : g_no_ld
      assign cell_ctl[i].load = 1'b0;
    end
    assign cell_ctl[i].shift = (state_r == ST_SCAN);

    if (i == NUM_SLOTS - 1) begin : g_wrap
      assign nb_armed = wrap_armed;
      assign nb_data  = cell_data[0];
    end else begin : g_link
      assign nb_armed = cell_armed[i+1];
      assign nb_data  = cell_data[i+1];
    end

    tahr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[i]),
      .ld_data  (ld_data),
      .nb_armed (nb_armed),
      .nb_data  (nb_data),
      .armed    (cell_armed[i]),
      .data     (cell_data[i])
    );
  end

  // Resolution of the slot at the head of the ring
  tahr_judge u_judge (
    .armed     (cell_armed[0]),
    .data      (cell_data[0]),
    .now_time  (tick_now_r),
    .other_key (tick_other_r),
    .rel_map   (tick_rel_r),
    .act       (head_act)
  );

  assign take       = (state_r == ST_SCAN) && (head_act != ACT_NONE) &&
                      (res_cnt_r < RES_CNT_W'(MAX_RES));
  assign wrap_armed = cell_armed[0] && !take;

  always_comb begin
    new_res.out_slot    = SLOT_FW'(scan_r);
    new_res.out_key     = cell_data[0].key;
    new_res.out_keycode = (head_act == ACT_TAP) ? cell_data[0].tap_code
                                                : cell_data[0].hold_code;
    new_res.action      = head_act;
    new_res.last        = 1'b0;
    none_res            = '0;
    none_res.action     = ACT_NONE;
    none_res.last       = 1'b1;
  end

  // Sequencer: scan, one-deep hold-back so the final result carries last
  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    res_cnt_nxt    = res_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    tick_now_nxt   = tick_now_r;
    tick_other_nxt = tick_other_r;
    tick_rel_nxt   = tick_rel_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.req_type == REQ_TICK) begin
            state_nxt      = ST_SCAN;
            scan_nxt       = '0;
            res_cnt_nxt    = '0;
            pend_valid_nxt = 1'b0;
            tick_now_nxt   = in_req.now_time;
            tick_other_nxt = in_req.other_key_pressed;
            tick_rel_nxt   = in_req.released_keys;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = none_res;
          end
        end
      end
      ST_SCAN: begin
        if (take) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          pend_valid_nxt = 1'b1;
          pend_nxt       = new_res;
          res_cnt_nxt    = res_cnt_r + RES_CNT_W'(1);
        end
        if (scan_r == CNT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_valid_r) begin
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end else begin
          out_nxt = none_res;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_r       <= '0;
      res_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      res_cnt_r    <= res_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
    tick_now_r   <= tick_now_nxt;
    tick_other_r <= tick_other_nxt;
    tick_rel_r   <= tick_rel_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`include "tap_hold_key_resolver_top_assert.svh"

  `TAHR_ASSERT_NEXT(a_flush_ends, state_r == ST_FLUSH, out_valid_r && out_r.last)
  `TAHR_ASSERT_NEXT(a_switch_done, accept && (in_req.req_type == REQ_SWITCH), out_valid_r && out_r.last && (out_r.action == ACT_NONE))
  `TAHR_ASSERT_SAME(a_mid_in_scan, out_valid_r && !out_r.last, (state_r == ST_SCAN) || (state_r == ST_FLUSH))
  `TAHR_ASSERT_SAME(a_pend_counted, pend_valid_r, res_cnt_r != '0)

endmodule
